// ===== rtl/core/uart_fifo_register_block_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the UART FIFO register block
// Same-cycle and next-cycle implication checks, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef UART_FIFO_REGISTER_BLOCK_MACROS_SVH
`define UART_FIFO_REGISTER_BLOCK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define UFRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufrb check failed");

// Consequent must hold in the cycle after the antecedent
`define UFRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufrb check failed");

`endif

// ===== rtl/core/ufrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ufrb_pkg
// Shared codes, constants and types of the UART FIFO register block.
// ----------------------------------------------------------------------------
`default_nettype none

package ufrb_pkg;

    localparam int FIFO_DEPTH_DEF = 32;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int BAUD_MOD_W     = 16;

    // transaction kinds
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_LINE  = 2'd2;
    localparam logic [1:0] REQ_SLOT  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_CTRL = 3'd0;
    localparam logic [2:0] REG_STAT = 3'd1;
    localparam logic [2:0] REG_DATA = 3'd2;
    localparam logic [2:0] REG_RXTH = 3'd3;
    localparam logic [2:0] REG_TXTH = 3'd4;
    localparam logic [2:0] REG_CTS  = 3'd5;
    localparam logic [2:0] REG_BAUD = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_RX_EMPTY    = 3'd1;
    localparam logic [2:0] ST_TX_FULL     = 3'd2;
    localparam logic [2:0] ST_READ_ONLY   = 3'd3;
    localparam logic [2:0] ST_RX_DISABLED = 3'd4;
    localparam logic [2:0] ST_BAD_VALUE   = 3'd5;
    localparam logic [2:0] ST_RX_OVERFLOW = 3'd6;

    // control register bit positions
    localparam int CTRL_TXE_BIT  = 0;
    localparam int CTRL_RXE_BIT  = 1;
    localparam int CTRL_MTXR_BIT = 13;
    localparam int CTRL_MRXR_BIT = 14;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_op_t;

    typedef struct packed {
        logic              txe;
        logic              rxe;
        logic              mtxr;
        logic              mrxr;
        logic [WORD_W-1:0] rx_thresh;
        logic [WORD_W-1:0] tx_thresh;
    } reg_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ufrb_ram.sv =====
// ----------------------------------------------------------------------------
// ufrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ufrb_fifo.sv =====
// ----------------------------------------------------------------------------
// ufrb_fifo
// Byte FIFO: head pointer and fill count around a RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_fifo_register_block_macros.svh"

module ufrb_fifo #(
    parameter int FIFO_DEPTH = ufrb_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ufrb_pkg::fifo_op_t                op,
    input  wire logic [ufrb_pkg::BYTE_W-1:0]       wdata,
    output logic      [$clog2(FIFO_DEPTH+1)-1:0]   count,
    output logic      [ufrb_pkg::BYTE_W-1:0]       rdata
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_addr;

    // tail = (head + count) wrapped once
    assign tail_sum  = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail_addr = (tail_sum >= (AW+1)'(FIFO_DEPTH))
                     ? AW'(tail_sum - (AW+1)'(FIFO_DEPTH))
                     : tail_sum[AW-1:0];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (op.pop)
        begin
            head_next  = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (op.push)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // read address is always the head: the popped byte is on rdata in the cycle after the pop
    ufrb_ram #(
        .WIDTH (ufrb_pkg::BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (op.push),
        .waddr (tail_addr),
        .wdata (wdata),
        .raddr (head_reg),
        .rdata (rdata)
    );

    assign count = count_reg;

    `UFRB_ASSERT_NOW(a_no_push_full, clk, rst_n, op.push, count_reg != CW'(FIFO_DEPTH))
    `UFRB_ASSERT_NOW(a_no_pop_empty, clk, rst_n, op.pop, count_reg != '0)
    `UFRB_ASSERT_NOW(a_single_op, clk, rst_n, op.push, !op.pop)
    `UFRB_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(FIFO_DEPTH))

endmodule

`default_nettype wire

// ===== rtl/core/ufrb_regs.sv =====
// ----------------------------------------------------------------------------
// ufrb_regs
// Stored configuration registers: write, read-back mux and value checks.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrb_regs #(
    parameter int FIFO_DEPTH = ufrb_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          we,
    input  wire logic [2:0]                    index,
    input  wire logic [ufrb_pkg::WORD_W-1:0]   wdata,
    output ufrb_pkg::reg_ctrl_t                ctrl,
    output logic      [ufrb_pkg::WORD_W-1:0]   rdata,
    output logic                               bad
);

    logic [ufrb_pkg::WORD_W-1:0] ctrl_reg;
    logic [ufrb_pkg::WORD_W-1:0] rxth_reg;
    logic [ufrb_pkg::WORD_W-1:0] txth_reg;
    logic [ufrb_pkg::WORD_W-1:0] cts_reg;
    logic [ufrb_pkg::WORD_W-1:0] baud_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            rxth_reg <= '0;
            txth_reg <= '0;
            cts_reg  <= '0;
            baud_reg <= '0;
        end
        else if (we)
        begin
            unique case (index)
                ufrb_pkg::REG_CTRL: ctrl_reg <= wdata;
                ufrb_pkg::REG_RXTH: rxth_reg <= wdata;
                ufrb_pkg::REG_TXTH: txth_reg <= wdata;
                ufrb_pkg::REG_CTS:  cts_reg  <= wdata;
                ufrb_pkg::REG_BAUD: baud_reg <= wdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            ufrb_pkg::REG_CTRL: rdata = ctrl_reg;
            ufrb_pkg::REG_CTS:  rdata = cts_reg;
            ufrb_pkg::REG_BAUD: rdata = baud_reg;
            default:            rdata = '0;
        endcase
    end

    // thresholds beyond the last slot, or a zero baud divisor, are flagged
    always_comb
    begin
        unique case (index) inside
            ufrb_pkg::REG_RXTH, ufrb_pkg::REG_TXTH:
                bad = wdata > ufrb_pkg::WORD_W'(FIFO_DEPTH - 1);
            ufrb_pkg::REG_BAUD:
                bad = wdata[ufrb_pkg::BAUD_MOD_W-1:0] == '0;
            default:
                bad = 1'b0;
        endcase
    end

    assign ctrl.txe       = ctrl_reg[ufrb_pkg::CTRL_TXE_BIT];
    assign ctrl.rxe       = ctrl_reg[ufrb_pkg::CTRL_RXE_BIT];
    assign ctrl.mtxr      = ctrl_reg[ufrb_pkg::CTRL_MTXR_BIT];
    assign ctrl.mrxr      = ctrl_reg[ufrb_pkg::CTRL_MRXR_BIT];
    assign ctrl.rx_thresh = rxth_reg;
    assign ctrl.tx_thresh = txth_reg;

endmodule

`default_nettype wire

// ===== rtl/core/uart_fifo_register_block.sv =====
// ----------------------------------------------------------------------------
// uart_fifo_register_block
// UART register block with receive and transmit byte FIFOs and interrupt.
// ----------------------------------------------------------------------------
// One transaction is taken at each rising edge with start high; busy is held
// low, so a transaction may be issued every cycle. Its result appears on the
// result ports with done high for one cycle, once it has passed the stage
// registers, which take the register and FIFO update, and then the output
// registers, which take the registered read of the FIFO RAM. The result
// cannot be held off, so sample it whenever done is high. The FIFO stores
// need no initialisation; the block is usable directly after reset.
`default_nettype none

`include "uart_fifo_register_block_macros.svh"

module uart_fifo_register_block #(
    parameter int FIFO_DEPTH = ufrb_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      req_type,
    input  wire logic [2:0]                      reg_index,
    input  wire logic [ufrb_pkg::WORD_W-1:0]     write_data,
    input  wire logic [ufrb_pkg::BYTE_W-1:0]     line_byte,
    output logic                                 done,
    output logic      [ufrb_pkg::WORD_W-1:0]     read_data,
    output logic                                 tx_valid,
    output logic      [ufrb_pkg::BYTE_W-1:0]     tx_byte,
    output logic                                 irq,
    output logic      [2:0]                      status_code
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic                          accept;
    ufrb_pkg::fifo_op_t            rx_op;
    ufrb_pkg::fifo_op_t            tx_op;
    logic [CW-1:0]                 rx_count;
    logic [CW-1:0]                 tx_count;
    logic [CW-1:0]                 tx_free;
    logic [ufrb_pkg::BYTE_W-1:0]   rx_rdata;
    logic [ufrb_pkg::BYTE_W-1:0]   tx_rdata;
    ufrb_pkg::reg_ctrl_t           ctrl;
    logic [ufrb_pkg::WORD_W-1:0]   reg_rdata;
    logic                          reg_bad;
    logic                          reg_we;
    logic                          irq_level;

    logic                          stage_valid_reg;
    logic [ufrb_pkg::WORD_W-1:0]   stage_rd_reg;
    logic [ufrb_pkg::WORD_W-1:0]   stage_rd_next;
    logic                          stage_rd_ram_reg;
    logic                          stage_rd_ram_next;
    logic                          stage_txv_reg;
    logic                          stage_txv_next;
    logic [2:0]                    stage_st_reg;
    logic [2:0]                    stage_st_next;

    logic                          done_reg;
    logic [ufrb_pkg::WORD_W-1:0]   read_data_reg;
    logic                          tx_valid_reg;
    logic [ufrb_pkg::BYTE_W-1:0]   tx_byte_reg;
    logic                          irq_reg;
    logic [2:0]                    status_reg;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign tx_free = CW'(FIFO_DEPTH) - tx_count;

    ufrb_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (rx_op),
        .wdata (line_byte),
        .count (rx_count),
        .rdata (rx_rdata)
    );

    ufrb_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_tx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (tx_op),
        .wdata (write_data[ufrb_pkg::BYTE_W-1:0]),
        .count (tx_count),
        .rdata (tx_rdata)
    );

    ufrb_regs #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (reg_we),
        .index (reg_index),
        .wdata (write_data),
        .ctrl  (ctrl),
        .rdata (reg_rdata),
        .bad   (reg_bad)
    );

    // decode the transaction and drive the FIFO and register updates
    always_comb
    begin
        rx_op             = '0;
        tx_op             = '0;
        reg_we            = 1'b0;
        stage_rd_next     = '0;
        stage_rd_ram_next = 1'b0;
        stage_txv_next    = 1'b0;
        stage_st_next     = ufrb_pkg::ST_OK;
        if (accept)
        begin
            unique case (req_type)
                ufrb_pkg::REQ_READ:
                begin
                    unique case (reg_index)
                        ufrb_pkg::REG_DATA:
                        begin
                            if (rx_count != '0)
                            begin
                                rx_op.pop         = 1'b1;
                                stage_rd_ram_next = 1'b1;
                            end
                            else
                            begin
                                stage_st_next = ufrb_pkg::ST_RX_EMPTY;
                            end
                        end
                        ufrb_pkg::REG_RXTH: stage_rd_next = ufrb_pkg::WORD_W'(rx_count);
                        ufrb_pkg::REG_TXTH: stage_rd_next = ufrb_pkg::WORD_W'(tx_free);
                        default:            stage_rd_next = reg_rdata;
                    endcase
                end
                ufrb_pkg::REQ_WRITE:
                begin
                    unique case (reg_index) inside
                        ufrb_pkg::REG_STAT:
                            stage_st_next = ufrb_pkg::ST_READ_ONLY;
                        ufrb_pkg::REG_DATA:
                        begin
                            if (tx_count != CW'(FIFO_DEPTH))
                            begin
                                tx_op.push = 1'b1;
                            end
                            else
                            begin
                                stage_st_next = ufrb_pkg::ST_TX_FULL;
                            end
                        end
                        ufrb_pkg::REG_CTRL, ufrb_pkg::REG_RXTH, ufrb_pkg::REG_TXTH,
                        ufrb_pkg::REG_CTS, ufrb_pkg::REG_BAUD:
                        begin
                            reg_we = 1'b1;
                            if (reg_bad)
                            begin
                                stage_st_next = ufrb_pkg::ST_BAD_VALUE;
                            end
                        end
                        default: ;
                    endcase
                end
                ufrb_pkg::REQ_LINE:
                begin
                    if (!ctrl.rxe)
                    begin
                        stage_st_next = ufrb_pkg::ST_RX_DISABLED;
                    end
                    else if (rx_count == CW'(FIFO_DEPTH))
                    begin
                        stage_st_next = ufrb_pkg::ST_RX_OVERFLOW;
                    end
                    else
                    begin
                        rx_op.push = 1'b1;
                    end
                end
                ufrb_pkg::REQ_SLOT:
                begin
                    if (ctrl.txe && tx_count != '0)
                    begin
                        tx_op.pop      = 1'b1;
                        stage_txv_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_rd_reg     <= stage_rd_next;
        stage_rd_ram_reg <= stage_rd_ram_next;
        stage_txv_reg    <= stage_txv_next;
        stage_st_reg     <= stage_st_next;
    end

    // state now holds the result of the staged transaction: evaluate the interrupt
    assign irq_level = (ctrl.mtxr && ufrb_pkg::WORD_W'(tx_free) >= ctrl.tx_thresh)
                    || (ctrl.mrxr && ufrb_pkg::WORD_W'(rx_count) >= ctrl.rx_thresh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= stage_rd_ram_reg ? ufrb_pkg::WORD_W'(rx_rdata) : stage_rd_reg;
        tx_valid_reg  <= stage_txv_reg;
        tx_byte_reg   <= stage_txv_reg ? tx_rdata : '0;
        irq_reg       <= irq_level;
        status_reg    <= stage_st_reg;
    end

    assign done        = done_reg;
    assign read_data   = read_data_reg;
    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign irq         = irq_reg;
    assign status_code = status_reg;

    `UFRB_ASSERT_NEXT(a_stage_follows_start, clk, rst_n, accept, stage_valid_reg)
    `UFRB_ASSERT_NEXT(a_done_follows_stage, clk, rst_n, stage_valid_reg, done_reg)
    `UFRB_ASSERT_NOW(a_tx_ok_status, clk, rst_n, done_reg && tx_valid_reg,
        status_reg == ufrb_pkg::ST_OK)
    `UFRB_ASSERT_NOW(a_one_fifo_op, clk, rst_n, rx_op.push || rx_op.pop,
        !tx_op.push && !tx_op.pop)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UART FIFO register block: a queue-fed driver
// issues bus reads and writes, line characters and transmit slots in random
// bursts. A shadow model of both FIFOs, the register words and the interrupt
// predicts every result, and the monitor checks each one field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam logic [31:0] DEPTH        = ufrb_pkg::FIFO_DEPTH_DEF;
    localparam int          NUM_REGS     = 7;
    localparam logic [2:0]  REG_NONE     = 3'd7;
    localparam int          ITEMS        = 700;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE_TICKS = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [31:0] wdata;
        logic [7:0]  lbyte;
        logic        hold;     // wait for every outstanding result first
    } uart_txn_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        txv;
        logic [7:0]  txb;
        logic        irq;
        logic [2:0]  st;
    } uart_result_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  req_type    = ufrb_pkg::REQ_READ;
    logic [2:0]  reg_index   = ufrb_pkg::REG_CTRL;
    logic [31:0] write_data  = '0;
    logic [7:0]  line_byte   = '0;
    logic        busy;
    logic        done;
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic [2:0]  status_code;

    uart_fifo_register_block dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .line_byte   (line_byte),
        .done        (done),
        .read_data   (read_data),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .irq         (irq),
        .status_code (status_code)
    );

    uart_txn_t    pending_txns[$];
    uart_result_t expected_results[$];

    // shadow state of the block
    logic [7:0]  rx_shadow[DEPTH];
    logic [7:0]  tx_shadow[DEPTH];
    logic [31:0] rx_used    = '0;
    logic [31:0] tx_used    = '0;
    int unsigned rx_rd_ptr  = 0;
    int unsigned tx_rd_ptr  = 0;
    logic [31:0] shadow_regs[NUM_REGS] = '{default: '0};

    logic taken       = 1'b0;
    bit   pause_next  = 1'b0;
    int   burst_left  = 1;
    int   gap_left    = 0;
    int   cycle_count = 0;
    int   fail_count  = 0;
    int   n_checked   = 0;
    int   n_tx_sent   = 0;
    int   n_rx_popped = 0;
    int   n_refused   = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic uart_result_t predict_uart(input uart_txn_t t);
        uart_result_t r;
        logic [31:0]  ctl;
        r = '0;
        case (t.kind)
            ufrb_pkg::REQ_READ:
            begin
                if (t.idx == ufrb_pkg::REG_DATA)
                begin
                    if (rx_used != 0)
                    begin
                        r.rdata   = {24'd0, rx_shadow[rx_rd_ptr]};
                        rx_rd_ptr = (rx_rd_ptr + 1) % DEPTH;
                        rx_used   = rx_used - 1;
                    end
                    else
                    begin
                        r.st = ufrb_pkg::ST_RX_EMPTY;
                    end
                end
                else if (t.idx == ufrb_pkg::REG_RXTH)
                begin
                    r.rdata = rx_used;
                end
                else if (t.idx == ufrb_pkg::REG_TXTH)
                begin
                    r.rdata = DEPTH - tx_used;
                end
                else if (t.idx != REG_NONE)
                begin
                    r.rdata = shadow_regs[t.idx];
                end
            end
            ufrb_pkg::REQ_WRITE:
            begin
                if (t.idx == ufrb_pkg::REG_STAT)
                begin
                    r.st = ufrb_pkg::ST_READ_ONLY;
                end
                else if (t.idx == ufrb_pkg::REG_DATA)
                begin
                    if (tx_used < DEPTH)
                    begin
                        tx_shadow[(tx_rd_ptr + tx_used) % DEPTH] = t.wdata[7:0];
                        tx_used = tx_used + 1;
                    end
                    else
                    begin
                        r.st = ufrb_pkg::ST_TX_FULL;
                    end
                end
                else if (t.idx != REG_NONE)
                begin
                    shadow_regs[t.idx] = t.wdata;
                    if ((t.idx == ufrb_pkg::REG_RXTH || t.idx == ufrb_pkg::REG_TXTH)
                        && t.wdata > DEPTH - 1)
                        r.st = ufrb_pkg::ST_BAD_VALUE;
                    if (t.idx == ufrb_pkg::REG_BAUD
                        && t.wdata[ufrb_pkg::BAUD_MOD_W-1:0] == '0)
                        r.st = ufrb_pkg::ST_BAD_VALUE;
                end
            end
            ufrb_pkg::REQ_LINE:
            begin
                if (!shadow_regs[ufrb_pkg::REG_CTRL][ufrb_pkg::CTRL_RXE_BIT])
                begin
                    r.st = ufrb_pkg::ST_RX_DISABLED;
                end
                else if (rx_used >= DEPTH)
                begin
                    r.st = ufrb_pkg::ST_RX_OVERFLOW;
                end
                else
                begin
                    rx_shadow[(rx_rd_ptr + rx_used) % DEPTH] = t.lbyte;
                    rx_used = rx_used + 1;
                end
            end
            default:
            begin
                if (shadow_regs[ufrb_pkg::REG_CTRL][ufrb_pkg::CTRL_TXE_BIT] && tx_used != 0)
                begin
                    r.txv     = 1'b1;
                    r.txb     = tx_shadow[tx_rd_ptr];
                    tx_rd_ptr = (tx_rd_ptr + 1) % DEPTH;
                    tx_used   = tx_used - 1;
                end
            end
        endcase
        // irq is set when either the transmit or the receive threshold condition holds
        ctl = shadow_regs[ufrb_pkg::REG_CTRL];
        if (ctl[ufrb_pkg::CTRL_MTXR_BIT]
            && (DEPTH - tx_used) >= shadow_regs[ufrb_pkg::REG_TXTH])
            r.irq = 1'b1;
        else if (ctl[ufrb_pkg::CTRL_MRXR_BIT]
                 && rx_used >= shadow_regs[ufrb_pkg::REG_RXTH])
            r.irq = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_txn(input logic [1:0] kind, input logic [2:0] idx,
                             input logic [31:0] wdata, input logic [7:0] lbyte);
        uart_txn_t t;
        t.kind     = kind;
        t.idx      = idx;
        t.wdata    = wdata;
        t.lbyte    = lbyte;
        t.hold     = pause_next;
        pause_next = 1'b0;
        pending_txns.push_back(t);
    endtask

    // driver: change inputs on the falling edge
    always @(negedge clk)
    begin : driver_proc
        logic      next_start;
        uart_txn_t t;
        if (rst_n)
        begin
            // hold the transaction until it has been taken
            next_start = start && !taken;
            if (!next_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_txns.size() != 0 &&
                         !(pending_txns[0].hold && expected_results.size() != 0))
                begin
                    t = pending_txns.pop_front();
                    req_type   <= t.kind;
                    reg_index  <= t.idx;
                    write_data <= t.wdata;
                    line_byte  <= t.lbyte;
                    next_start = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            start <= next_start;
        end
    end

    // monitor: sample on the rising edge, check results, predict new ones
    always @(posedge clk)
    begin : monitor_proc
        uart_result_t want;
        uart_txn_t    t;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[uart_fifo_register_block] ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.rdata, read_data);
                    check_field("tx_valid", {31'd0, want.txv}, {31'd0, tx_valid});
                    check_field("tx_byte", {24'd0, want.txb}, {24'd0, tx_byte});
                    check_field("irq", {31'd0, want.irq}, {31'd0, irq});
                    check_field("status_code", {29'd0, want.st}, {29'd0, status_code});
                    n_checked++;
                end
            end
            taken <= start && !busy;
            if (start && !busy)
            begin
                t.kind  = req_type;
                t.idx   = reg_index;
                t.wdata = write_data;
                t.lbyte = line_byte;
                t.hold  = 1'b0;
                want = predict_uart(t);
                if (want.txv)
                    n_tx_sent++;
                if (t.kind == ufrb_pkg::REQ_READ && t.idx == ufrb_pkg::REG_DATA
                    && want.st == ufrb_pkg::ST_OK)
                    n_rx_popped++;
                if (want.st == ufrb_pkg::ST_TX_FULL || want.st == ufrb_pkg::ST_RX_OVERFLOW)
                    n_refused++;
                expected_results.push_back(want);
            end
        end
    end

    initial
    begin : stimulus_proc
        int          n;
        int          sel;
        bit          mid_pause;
        logic [31:0] v;
        logic [2:0]  th_reg;
        mid_pause = 1'b0;

        // directed: reset values, error codes and FIFO edge cases
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_CTRL, '0, '0);
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_STAT, '1, '1);
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_DATA, '0, '0);
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_RXTH, '0, '0);
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_TXTH, '0, '0);
        queue_txn(ufrb_pkg::REQ_READ,  REG_NONE, '0, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_STAT, '1, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, REG_NONE, '1, '0);
        queue_txn(ufrb_pkg::REQ_LINE,  ufrb_pkg::REG_DATA, '0, 8'hFF);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_DATA, 32'hFFFF_FFA5, '0);
        queue_txn(ufrb_pkg::REQ_SLOT,  ufrb_pkg::REG_DATA, '0, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_RXTH, DEPTH, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_TXTH, '1, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_BAUD, 32'hFFFF_0000, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_BAUD, 32'h0000_FFFF, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_CTS,  '1, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_CTRL, '1, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_RXTH, '0, '0);
        queue_txn(ufrb_pkg::REQ_SLOT,  ufrb_pkg::REG_CTRL, '1, '1);
        queue_txn(ufrb_pkg::REQ_SLOT,  ufrb_pkg::REG_CTRL, '0, '0);
        queue_txn(ufrb_pkg::REQ_LINE,  ufrb_pkg::REG_CTRL, '1, 8'h00);
        queue_txn(ufrb_pkg::REQ_LINE,  ufrb_pkg::REG_CTRL, '0, 8'hFF);
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_DATA, '0, '0);
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_RXTH, '0, '0);
        queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_TXTH, DEPTH - 1, '0);
        queue_txn(ufrb_pkg::REQ_READ,  ufrb_pkg::REG_CTS,  '0, '0);

        // random: FIFO fill and drain runs mixed with register traffic
        pause_next = 1'b1;
        while (pending_txns.size() < ITEMS)
        begin
            if (!mid_pause && pending_txns.size() > ITEMS / 2)
            begin
                pause_next = 1'b1;
                mid_pause  = 1'b1;
            end
            sel = $urandom_range(0, 99);
            n   = $urandom_range(1, 40);
            if (sel < 15)
            begin
                repeat (n) queue_txn(ufrb_pkg::REQ_LINE, 3'($urandom()), $urandom(),
                                     8'($urandom()));
            end
            else if (sel < 30)
            begin
                repeat (n) queue_txn(ufrb_pkg::REQ_READ, ufrb_pkg::REG_DATA, $urandom(),
                                     8'($urandom()));
            end
            else if (sel < 45)
            begin
                repeat (n) queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_DATA, $urandom(),
                                     8'($urandom()));
            end
            else if (sel < 60)
            begin
                repeat (n) queue_txn(ufrb_pkg::REQ_SLOT, 3'($urandom()), $urandom(),
                                     8'($urandom()));
            end
            else if (sel < 70)
            begin
                v = $urandom();
                if ($urandom_range(0, 6) != 0) v[ufrb_pkg::CTRL_TXE_BIT] = 1'b1;
                if ($urandom_range(0, 6) != 0) v[ufrb_pkg::CTRL_RXE_BIT] = 1'b1;
                queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_CTRL, v, 8'($urandom()));
            end
            else if (sel < 78)
            begin
                th_reg = $urandom_range(0, 1) ? ufrb_pkg::REG_RXTH : ufrb_pkg::REG_TXTH;
                if ($urandom_range(0, 9) == 0)
                    v = $urandom_range(0, 1) ? $urandom() : DEPTH;
                else
                    v = $urandom_range(0, DEPTH - 1);
                queue_txn(ufrb_pkg::REQ_WRITE, th_reg, v, 8'($urandom()));
            end
            else if (sel < 83)
            begin
                v = $urandom();
                if ($urandom_range(0, 4) == 0) v[ufrb_pkg::BAUD_MOD_W-1:0] = '0;
                queue_txn(ufrb_pkg::REQ_WRITE, ufrb_pkg::REG_BAUD, v, 8'($urandom()));
            end
            else if (sel < 93)
            begin
                queue_txn(ufrb_pkg::REQ_READ, 3'($urandom()), $urandom(), 8'($urandom()));
            end
            else if (sel < 98)
            begin
                queue_txn(2'($urandom()), 3'($urandom()), $urandom(), 8'($urandom()));
            end
            else
            begin
                queue_txn(ufrb_pkg::REQ_WRITE, 3'($urandom()), $urandom(), 8'($urandom()));
            end
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_txns.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end

        $display("Checked %0d transactions: %0d characters sent on the line,", n_checked,
                 n_tx_sent);
        $display("%0d received characters read back, %0d pushes refused on a full FIFO.",
                 n_rx_popped, n_refused);
        if (fail_count == 0)
            $display("[uart_fifo_register_block] OK");
        else
            $display("[uart_fifo_register_block] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ufrb_pkg.sv
rtl/core/ufrb_ram.sv
rtl/core/ufrb_fifo.sv
rtl/core/ufrb_regs.sv
rtl/core/uart_fifo_register_block.sv
tb/tb_top.sv
